[rtl/im2col_patch_address_generator_assert.svh]
// Assertion helpers for the im2col address generator controller (ipag_ctrl).
// Each macro expects the enclosing module to have i_clk and i_rst_n.
`ifndef IM2COL_PATCH_ADDRESS_GENERATOR_ASSERT_SVH
`define IM2COL_PATCH_ADDRESS_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPAG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("im2col address generator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define IPAG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("im2col address generator: next-cycle check failed");

`endif

[rtl/ipag_pkg.sv]
package ipag_pkg;

    // Fixed widths of the register port, of the counters that do not scale and of the payload fields.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;
    localparam int CHAN_BITS      = 12;
    localparam int KERN_BITS      = 8;
    localparam int FIELD_BITS     = 32;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CHANNEL_COUNT = 3'd0,
        REG_IMAGE_DIMS    = 3'd1,
        REG_KERNEL_DIMS   = 3'd2,
        REG_RESULT_DIMS   = 3'd3,
        REG_STRIDE_PAIR   = 3'd4,
        REG_PADDING_PAIR  = 3'd5,
        REG_DILATION_PAIR = 3'd6
    } t_cfg_reg;

    // Reset values of the configuration registers.
    localparam logic [11:0] RST_CHANNEL_COUNT = 12'd1;
    localparam logic [23:0] RST_IMAGE_DIMS    = 24'd4097;
    localparam logic [15:0] RST_KERNEL_DIMS   = 16'd257;
    localparam logic [23:0] RST_RESULT_DIMS   = 24'd4097;
    localparam logic [15:0] RST_STRIDE_PAIR   = 16'd257;
    localparam logic [15:0] RST_PADDING_PAIR  = 16'd0;
    localparam logic [15:0] RST_DILATION_PAIR = 16'd257;

    // Input request payload.
    typedef struct packed {
        logic [FIELD_BITS-1:0] image_base;
        logic                  restart;
    } t_in_req;

    // Result payload.
    typedef struct packed {
        logic [FIELD_BITS-1:0] read_address;
        logic                  is_padding;
        logic [FIELD_BITS-1:0] buffer_index;
        logic                  last;
    } t_out_item;

    // Step commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic mul;
        logic add;
        logic adr;
        logic load_out;
    } t_dp_cmd;

endpackage

[rtl/ipag_ctrl.sv]
`include "im2col_patch_address_generator_assert.svh"

module ipag_ctrl
    import ipag_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_ADR,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;
    logic   in_ready;

    assign in_ready  = (r_state == S_IDLE);
    assign slot_free = !r_out_valid || i_out_ready;

    // Step sequence: one request walks through four datapath steps.
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        n_out_valid    = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_ADR;
            end
            S_ADR: begin
                o_cmd.adr = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;

    `IPAG_ASSERT_NEXT(a_accept_starts, i_in_valid && in_ready, r_state == S_MUL)
    `IPAG_ASSERT_SAME(a_load_needs_slot, o_cmd.load_out, !r_out_valid || i_out_ready)
    `IPAG_ASSERT_NEXT(a_fin_delivers, r_state == S_FIN && slot_free,
                      r_out_valid && r_state == S_IDLE)

endmodule

[rtl/ipag_dp.sv]
module ipag_dp
    import ipag_pkg::*;
#(
    parameter int DIM_BITS  = 12,
    parameter int ADDR_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  t_in_req                   i_in_data,
    input  t_dp_cmd                   i_cmd,
    output t_out_item                 o_out_data
);

    localparam int PROD_W = (DIM_BITS + KERN_BITS > 2 * KERN_BITS) ?
                            DIM_BITS + KERN_BITS : 2 * KERN_BITS;
    localparam int POS_W  = PROD_W + 2;
    localparam int HW_W   = 2 * DIM_BITS;
    localparam int CHW_W  = CHAN_BITS + HW_W;

    // Configuration registers.
    logic [11:0] r_channel_count;
    logic [23:0] r_image_dims;
    logic [15:0] r_kernel_dims;
    logic [23:0] r_result_dims;
    logic [15:0] r_stride_pair;
    logic [15:0] r_padding_pair;
    logic [15:0] r_dilation_pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= RST_CHANNEL_COUNT;
            r_image_dims    <= RST_IMAGE_DIMS;
            r_kernel_dims   <= RST_KERNEL_DIMS;
            r_result_dims   <= RST_RESULT_DIMS;
            r_stride_pair   <= RST_STRIDE_PAIR;
            r_padding_pair  <= RST_PADDING_PAIR;
            r_dilation_pair <= RST_DILATION_PAIR;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[11:0];
                REG_IMAGE_DIMS:    r_image_dims    <= i_cfg_data[23:0];
                REG_KERNEL_DIMS:   r_kernel_dims   <= i_cfg_data[15:0];
                REG_RESULT_DIMS:   r_result_dims   <= i_cfg_data[23:0];
                REG_STRIDE_PAIR:   r_stride_pair   <= i_cfg_data[15:0];
                REG_PADDING_PAIR:  r_padding_pair  <= i_cfg_data[15:0];
                REG_DILATION_PAIR: r_dilation_pair <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Field extraction from the packed registers.
    logic [DIM_BITS-1:0]  img_h;
    logic [DIM_BITS-1:0]  img_w;
    logic [DIM_BITS-1:0]  res_h;
    logic [DIM_BITS-1:0]  res_w;
    logic [KERN_BITS-1:0] ker_h;
    logic [KERN_BITS-1:0] ker_w;

    assign img_h = DIM_BITS'(r_image_dims >> DIM_BITS);
    assign img_w = r_image_dims[DIM_BITS-1:0];
    assign res_h = DIM_BITS'(r_result_dims >> DIM_BITS);
    assign res_w = r_result_dims[DIM_BITS-1:0];
    assign ker_h = r_kernel_dims[15:8];
    assign ker_w = r_kernel_dims[7:0];

    // Final counter values; a zero bound behaves as a bound of one.
    logic [DIM_BITS-1:0]  fin_oh;
    logic [DIM_BITS-1:0]  fin_ow;
    logic [CHAN_BITS-1:0] fin_c;
    logic [KERN_BITS-1:0] fin_kh;
    logic [KERN_BITS-1:0] fin_kw;

    assign fin_oh = (res_h == '0) ? '0 : res_h - 1'b1;
    assign fin_ow = (res_w == '0) ? '0 : res_w - 1'b1;
    assign fin_c  = (r_channel_count == '0) ? '0 : r_channel_count - 1'b1;
    assign fin_kh = (ker_h == '0) ? '0 : ker_h - 1'b1;
    assign fin_kw = (ker_w == '0) ? '0 : ker_w - 1'b1;

    // Request latch.
    logic [FIELD_BITS-1:0] r_base;
    logic                  r_restart;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_base    <= i_in_data.image_base;
            r_restart <= i_in_data.restart;
        end
    end

    // Position counters; a restart request forces them to the first element.
    logic [DIM_BITS-1:0]   r_orow;
    logic [DIM_BITS-1:0]   r_ocol;
    logic [CHAN_BITS-1:0]  r_chan_cnt;
    logic [KERN_BITS-1:0]  r_krow;
    logic [KERN_BITS-1:0]  r_kcol;
    logic [FIELD_BITS-1:0] r_elem;

    logic [DIM_BITS-1:0]   cur_orow;
    logic [DIM_BITS-1:0]   cur_ocol;
    logic [CHAN_BITS-1:0]  cur_chan;
    logic [KERN_BITS-1:0]  cur_krow;
    logic [KERN_BITS-1:0]  cur_kcol;
    logic [FIELD_BITS-1:0] cur_elem;

    assign cur_orow = r_restart ? '0 : r_orow;
    assign cur_ocol = r_restart ? '0 : r_ocol;
    assign cur_chan = r_restart ? '0 : r_chan_cnt;
    assign cur_krow = r_restart ? '0 : r_krow;
    assign cur_kcol = r_restart ? '0 : r_kcol;
    assign cur_elem = r_restart ? '0 : r_elem;

    logic end_kw;
    logic end_kh;
    logic end_c;
    logic end_ow;
    logic end_oh;
    logic is_last;

    assign end_kw  = cur_kcol >= fin_kw;
    assign end_kh  = cur_krow >= fin_kh;
    assign end_c   = cur_chan >= fin_c;
    assign end_ow  = cur_ocol >= fin_ow;
    assign end_oh  = cur_orow >= fin_oh;
    assign is_last = end_kw && end_kh && end_c && end_ow && end_oh;

    logic [DIM_BITS-1:0]   n_orow;
    logic [DIM_BITS-1:0]   n_ocol;
    logic [CHAN_BITS-1:0]  n_chan_cnt;
    logic [KERN_BITS-1:0]  n_krow;
    logic [KERN_BITS-1:0]  n_kcol;
    logic [FIELD_BITS-1:0] n_elem;

    // Innermost-first carry chain; the final element wraps everything to zero.
    always_comb begin
        n_orow     = cur_orow;
        n_ocol     = cur_ocol;
        n_chan_cnt = cur_chan;
        n_krow     = cur_krow;
        n_kcol     = cur_kcol;
        n_elem     = cur_elem + 1'b1;
        if (is_last) begin
            n_orow     = '0;
            n_ocol     = '0;
            n_chan_cnt = '0;
            n_krow     = '0;
            n_kcol     = '0;
            n_elem     = '0;
        end else if (!end_kw) begin
            n_kcol = cur_kcol + 1'b1;
        end else if (!end_kh) begin
            n_kcol = '0;
            n_krow = cur_krow + 1'b1;
        end else if (!end_c) begin
            n_kcol     = '0;
            n_krow     = '0;
            n_chan_cnt = cur_chan + 1'b1;
        end else if (!end_ow) begin
            n_kcol     = '0;
            n_krow     = '0;
            n_chan_cnt = '0;
            n_ocol     = cur_ocol + 1'b1;
        end else begin
            n_kcol     = '0;
            n_krow     = '0;
            n_chan_cnt = '0;
            n_ocol     = '0;
            n_orow     = cur_orow + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orow     <= '0;
            r_ocol     <= '0;
            r_chan_cnt <= '0;
            r_krow     <= '0;
            r_kcol     <= '0;
            r_elem     <= '0;
        end else if (i_cmd.mul) begin
            r_orow     <= n_orow;
            r_ocol     <= n_ocol;
            r_chan_cnt <= n_chan_cnt;
            r_krow     <= n_krow;
            r_kcol     <= n_kcol;
            r_elem     <= n_elem;
        end
    end

    // First step: stride and dilation products, image plane size.
    logic [PROD_W-1:0]     r_prod_rs;
    logic [PROD_W-1:0]     r_prod_kd;
    logic [PROD_W-1:0]     r_prod_cs;
    logic [PROD_W-1:0]     r_prod_cd;
    logic [HW_W-1:0]       r_plane;
    logic [CHAN_BITS-1:0]  r_chan;
    logic [FIELD_BITS-1:0] r_index;
    logic                  r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod_rs <= PROD_W'(cur_orow) * PROD_W'(r_stride_pair[15:8]);
            r_prod_kd <= PROD_W'(cur_krow) * PROD_W'(r_dilation_pair[15:8]);
            r_prod_cs <= PROD_W'(cur_ocol) * PROD_W'(r_stride_pair[7:0]);
            r_prod_cd <= PROD_W'(cur_kcol) * PROD_W'(r_dilation_pair[7:0]);
            r_plane   <= HW_W'(img_h) * HW_W'(img_w);
            r_chan    <= cur_chan;
            r_index   <= cur_elem;
            r_last    <= is_last;
        end
    end

    // Second step: signed input position, bounds check, channel offset.
    logic signed [POS_W-1:0] pos_h;
    logic signed [POS_W-1:0] pos_w;
    logic                    outside;
    logic [CHW_W-1:0]        chan_off;

    assign pos_h = $signed(POS_W'(r_prod_rs)) + $signed(POS_W'(r_prod_kd))
                 - $signed(POS_W'(r_padding_pair[15:8]));
    assign pos_w = $signed(POS_W'(r_prod_cs)) + $signed(POS_W'(r_prod_cd))
                 - $signed(POS_W'(r_padding_pair[7:0]));
    assign outside = pos_h[POS_W-1] || pos_w[POS_W-1]
                  || (POS_W'(pos_h) >= POS_W'(img_h))
                  || (POS_W'(pos_w) >= POS_W'(img_w));
    assign chan_off = CHW_W'(r_chan) * CHW_W'(r_plane);

    logic                 r_pad;
    logic [DIM_BITS-1:0]  r_ih;
    logic [DIM_BITS-1:0]  r_iw;
    logic [ADDR_BITS-1:0] r_chan_off;

    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            r_pad      <= outside;
            r_ih       <= pos_h[DIM_BITS-1:0];
            r_iw       <= pos_w[DIM_BITS-1:0];
            r_chan_off <= ADDR_BITS'(chan_off);
        end
    end

    // Third step: row offset and base plus channel offset.
    logic [HW_W-1:0]      r_row_off;
    logic [ADDR_BITS-1:0] r_partial;

    always_ff @(posedge i_clk) begin
        if (i_cmd.adr) begin
            r_row_off <= HW_W'(r_ih) * HW_W'(img_w);
            r_partial <= ADDR_BITS'(r_base) + r_chan_off;
        end
    end

    // Final step: full address into the output register.
    logic [ADDR_BITS-1:0] full_addr;
    t_out_item            r_out;

    assign full_addr = r_partial + ADDR_BITS'(r_row_off) + ADDR_BITS'(r_iw);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.read_address <= r_pad ? '0 : FIELD_BITS'(full_addr);
            r_out.is_padding   <= r_pad;
            r_out.buffer_index <= r_index;
            r_out.last         <= r_last;
        end
    end

    assign o_out_data = r_out;

endmodule

[rtl/im2col_patch_address_generator.sv]
// im2col patch address generator.
// Input channel (i_in_valid / o_in_ready / i_in_data): each request carries the
// image base address and a restart bit, and yields exactly one result: the image
// read address of the next column-buffer element (or a padding flag), its
// buffer index and a last marker on the final element of the stream.
// Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
// is always ready; the user must write it only while no request is in flight,
// which the block does not enforce. A request is taken in the idle state, then
// passes four datapath steps (products, position and bounds, offsets, final
// sum) into the output register; no new request is taken until the current one
// has left the last step.
// The result sits in an output register; while the receiver stalls the next
// request is still accepted and computed, and waits in the last step until the
// register drains.
// Reset (i_rst_n low at a clock edge) restores the default registers (1x1
// image, kernel and output, unit stride and dilation, no padding) and returns
// all counters to the first element.
module im2col_patch_address_generator
    import ipag_pkg::*;
#(
    parameter int DIM_BITS  = 12,
    parameter int ADDR_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  t_in_req                   i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output t_out_item                 o_out_data
);

    t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    // Sequencer.
    ipag_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // Counters, configuration and address arithmetic.
    ipag_dp #(
        .DIM_BITS  (DIM_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_out_data  (o_out_data)
    );

endmodule

[tb/im2col_patch_address_generator_tb.sv]
module im2col_patch_address_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ipag_pkg::*;

    // Index that maps to no register; writes to it must be dropped.
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;
    localparam int MAX_WAIT = 14;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_CYCLES = 20;

    // Geometry of one convolution setting, field by field.
    typedef struct packed {
        logic [11:0] chan;
        logic [11:0] img_h;
        logic [11:0] img_w;
        logic [7:0]  ker_h;
        logic [7:0]  ker_w;
        logic [11:0] out_h;
        logic [11:0] out_w;
        logic [7:0]  str_v;
        logic [7:0]  str_h;
        logic [7:0]  pad_v;
        logic [7:0]  pad_h;
        logic [7:0]  dil_v;
        logic [7:0]  dil_h;
    } t_geometry;

    // Patch stream predictor and the queue of addresses it expects.
    class patch_scoreboard;
        bit [11:0] chan_count;
        bit [23:0] image_dims;
        bit [15:0] kernel_dims;
        bit [23:0] result_dims;
        bit [15:0] stride_pair;
        bit [15:0] padding_pair;
        bit [15:0] dilation_pair;
        bit [11:0] row_cnt;
        bit [11:0] col_cnt;
        bit [11:0] chan_cnt;
        bit [7:0]  krow_cnt;
        bit [7:0]  kcol_cnt;
        bit [31:0] elem_idx;
        t_out_item expected_q[$];
        int unsigned mismatches;
        int unsigned requests_seen;
        int unsigned results_seen;
        int unsigned pads_seen;
        int unsigned ends_seen;

        function new();
            chan_count    = RST_CHANNEL_COUNT;
            image_dims    = RST_IMAGE_DIMS;
            kernel_dims   = RST_KERNEL_DIMS;
            result_dims   = RST_RESULT_DIMS;
            stride_pair   = RST_STRIDE_PAIR;
            padding_pair  = RST_PADDING_PAIR;
            dilation_pair = RST_DILATION_PAIR;
            clear_position();
        endfunction

        function void clear_position();
            row_cnt  = '0;
            col_cnt  = '0;
            chan_cnt = '0;
            krow_cnt = '0;
            kcol_cnt = '0;
            elem_idx = '0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_CHANNEL_COUNT: chan_count    = data[11:0];
                REG_IMAGE_DIMS:    image_dims    = data[23:0];
                REG_KERNEL_DIMS:   kernel_dims   = data[15:0];
                REG_RESULT_DIMS:   result_dims   = data[23:0];
                REG_STRIDE_PAIR:   stride_pair   = data[15:0];
                REG_PADDING_PAIR:  padding_pair  = data[15:0];
                REG_DILATION_PAIR: dilation_pair = data[15:0];
                default: ;
            endcase
        endfunction

        // Work out the element for one accepted request and step the counters.
        function void note_request(t_in_req req);
            bit [11:0] in_h, in_w, o_h, o_w, f_oh, f_ow, f_c;
            bit [7:0]  k_h, k_w, f_kh, f_kw;
            longint    ih, iw;
            bit [63:0] addr;
            bit        pad, end_kw, end_kh, end_c, end_ow, end_oh;
            t_out_item item_next;

            if (req.restart) begin
                clear_position();
            end
            in_h = image_dims[23:12];
            in_w = image_dims[11:0];
            k_h  = kernel_dims[15:8];
            k_w  = kernel_dims[7:0];
            o_h  = result_dims[23:12];
            o_w  = result_dims[11:0];

            // Input position, exact and signed.
            ih = longint'(row_cnt) * longint'(stride_pair[15:8]) - longint'(padding_pair[15:8])
               + longint'(krow_cnt) * longint'(dilation_pair[15:8]);
            iw = longint'(col_cnt) * longint'(stride_pair[7:0]) - longint'(padding_pair[7:0])
               + longint'(kcol_cnt) * longint'(dilation_pair[7:0]);
            pad = !(ih >= 0 && ih < longint'(in_h) && iw >= 0 && iw < longint'(in_w));
            addr = 64'(req.image_base) + 64'(chan_cnt) * 64'(in_h) * 64'(in_w)
                 + 64'(ih) * 64'(in_w) + 64'(iw);

            // A zero bound counts as one; a counter past its bound counts as final.
            f_oh = (o_h == 0) ? 12'd0 : o_h - 12'd1;
            f_ow = (o_w == 0) ? 12'd0 : o_w - 12'd1;
            f_c  = (chan_count == 0) ? 12'd0 : chan_count - 12'd1;
            f_kh = (k_h == 0) ? 8'd0 : k_h - 8'd1;
            f_kw = (k_w == 0) ? 8'd0 : k_w - 8'd1;
            end_kw = kcol_cnt >= f_kw;
            end_kh = krow_cnt >= f_kh;
            end_c  = chan_cnt >= f_c;
            end_ow = col_cnt >= f_ow;
            end_oh = row_cnt >= f_oh;

            item_next.read_address = pad ? '0 : addr[31:0];
            item_next.is_padding   = pad;
            item_next.buffer_index = elem_idx;
            item_next.last         = end_kw && end_kh && end_c && end_ow && end_oh;
            expected_q.push_back(item_next);
            requests_seen++;
            if (pad) begin
                pads_seen++;
            end

            // Step the counters innermost first, or wrap after the final element.
            if (item_next.last) begin
                ends_seen++;
                clear_position();
            end else begin
                elem_idx++;
                if (!end_kw) begin
                    kcol_cnt++;
                end else begin
                    kcol_cnt = '0;
                    if (!end_kh) begin
                        krow_cnt++;
                    end else begin
                        krow_cnt = '0;
                        if (!end_c) begin
                            chan_cnt++;
                        end else begin
                            chan_cnt = '0;
                            if (!end_ow) begin
                                col_cnt++;
                            end else begin
                                col_cnt = '0;
                                row_cnt++;
                            end
                        end
                    end
                end
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: result with nothing expected: addr=%h pad=%b idx=%h last=%b",
                             $realtime, got.read_address, got.is_padding, got.buffer_index,
                             got.last);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got.read_address !== want.read_address || got.is_padding !== want.is_padding ||
                got.buffer_index !== want.buffer_index || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: mismatch: expected addr=%h pad=%b idx=%h last=%b",
                             $realtime, want.read_address, want.is_padding, want.buffer_index,
                             want.last);
                    $display("%0t:           actual   addr=%h pad=%b idx=%h last=%b",
                             $realtime, got.read_address, got.is_padding, got.buffer_index,
                             got.last);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_ready;
    t_in_req                   i_in_data;
    logic                      o_out_valid;
    logic                      i_out_ready;
    t_out_item                 o_out_data;

    patch_scoreboard sb;
    bit              quiet_send;
    bit              quiet_recv;
    int unsigned     settings_used;

    im2col_patch_address_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the handshakes hang.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // One register write; valid stays up so writes can run back to back.
    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // Wait for the pipeline to empty, then load a whole geometry.
    task automatic program_geometry(input t_geometry g, input bit stray);
        while (sb.pending() != 0) @(posedge i_clk);
        cfg_write(REG_CHANNEL_COUNT, {12'($urandom), g.chan});
        cfg_write(REG_IMAGE_DIMS, {g.img_h, g.img_w});
        cfg_write(REG_KERNEL_DIMS, {8'($urandom), g.ker_h, g.ker_w});
        cfg_write(REG_RESULT_DIMS, {g.out_h, g.out_w});
        cfg_write(REG_STRIDE_PAIR, {8'($urandom), g.str_v, g.str_h});
        cfg_write(REG_PADDING_PAIR, {8'($urandom), g.pad_v, g.pad_h});
        cfg_write(REG_DILATION_PAIR, {8'($urandom), g.dil_v, g.dil_h});
        if (stray) begin
            cfg_write(REG_UNUSED, 24'($urandom));
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Send one request after a random gap; valid stays up if the gap is zero.
    task automatic send_request(input logic [31:0] base, input logic restart);
        int gap;
        t_in_req req;
        gap = quiet_send ? 0 : $urandom_range(0, MAX_WAIT);
        req.image_base = base;
        req.restart    = restart;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(req);
    endtask

    // Small random geometry, now and then with one field at its extreme.
    function automatic t_geometry random_geometry();
        t_geometry g;
        g.chan  = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(1, 2));
        g.img_h = 12'($urandom_range(0, 6));
        g.img_w = 12'($urandom_range(0, 6));
        g.ker_h = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 3));
        g.ker_w = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 3));
        g.out_h = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(1, 3));
        g.out_w = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(1, 3));
        g.str_v = 8'($urandom_range(0, 3));
        g.str_h = 8'($urandom_range(0, 3));
        g.pad_v = 8'($urandom_range(0, 2));
        g.pad_h = 8'($urandom_range(0, 2));
        g.dil_v = 8'($urandom_range(0, 3));
        g.dil_h = 8'($urandom_range(0, 3));
        case ($urandom_range(0, 15))
            0: g.chan  = 12'hFFF;
            1: g.img_h = 12'hFFF;
            2: g.img_w = 12'hFFF;
            3: g.str_v = 8'hFF;
            4: g.str_h = 8'hFF;
            5: g.pad_v = 8'hFF;
            6: g.pad_h = 8'hFF;
            7: g.dil_v = 8'hFF;
            8: g.dil_h = 8'hFF;
            default: ;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] random_base();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return {28'hFFF_FFFF, 4'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // Result side: random stall before each result, with quiet stretches.
    initial begin
        int stall;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = quiet_recv ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_result(o_out_data);
        end
    end

    // Main sequence: reset, directed cases, then random settings and streams.
    initial begin
        t_geometry g;
        int count;
        sb = new();
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_CHANNEL_COUNT;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default 1x1 geometry: every element is the last and reads the base.
        send_request(32'h0000_0000, 1'b0);
        send_request(32'hFFFF_FFFF, 1'b0);
        send_request(32'h5A5A_A5A5, 1'b1);
        i_in_valid <= 1'b0;

        // Small padded window over a 2x2 image.
        g = '{chan: 12'd1, img_h: 12'd2, img_w: 12'd2, ker_h: 8'd2, ker_w: 8'd2,
              out_h: 12'd1, out_w: 12'd2, str_v: 8'd1, str_h: 8'd1,
              pad_v: 8'd1, pad_h: 8'd1, dil_v: 8'd1, dil_h: 8'd1};
        program_geometry(g, 1'b0);
        send_request(32'h0000_0100, 1'b1);
        for (int i = 1; i < 8; i++) begin
            send_request(32'h0000_0100 + 32'(i), 1'b0);
        end
        i_in_valid <= 1'b0;

        // All bounds and the image size zero; also a write to the unused index.
        g = '0;
        program_geometry(g, 1'b1);
        send_request(32'h1234_5678, 1'b0);
        send_request(32'hFFFF_FFFF, 1'b1);
        send_request(32'h0000_0000, 1'b0);
        i_in_valid <= 1'b0;

        // Largest geometry without padding: the address wraps past the top.
        g = '{chan: 12'hFFF, img_h: 12'hFFF, img_w: 12'hFFF, ker_h: 8'hFF, ker_w: 8'hFF,
              out_h: 12'hFFF, out_w: 12'hFFF, str_v: 8'hFF, str_h: 8'hFF,
              pad_v: 8'h00, pad_h: 8'h00, dil_v: 8'hFF, dil_h: 8'hFF};
        program_geometry(g, 1'b0);
        send_request(32'hFFFF_FFF0, 1'b1);
        for (int i = 0; i < 4; i++) begin
            send_request(32'hFFFF_FFF0, 1'b0);
        end
        i_in_valid <= 1'b0;

        // Largest padding with zero stride.
        g.pad_v = 8'hFF;
        g.pad_h = 8'hFF;
        g.str_v = 8'h00;
        g.str_h = 8'h00;
        program_geometry(g, 1'b0);
        send_request(32'h8000_0000, 1'b1);
        send_request(32'h7FFF_FFFF, 1'b0);
        send_request(32'hFFFF_FFFF, 1'b0);
        i_in_valid <= 1'b0;

        // Random settings; the counters carry over unless a restart comes first.
        for (int phase = 0; phase < 16; phase++) begin
            quiet_send = ($urandom_range(0, 3) == 0);
            quiet_recv = ($urandom_range(0, 3) == 0);
            program_geometry(random_geometry(), $urandom_range(0, 3) == 0);
            count = $urandom_range(80, 120);
            send_request(random_base(), 1'($urandom_range(0, 1)));
            for (int i = 1; i < count; i++) begin
                send_request(random_base(), $urandom_range(0, 24) == 0);
            end
            i_in_valid <= 1'b0;
        end

        // Drain and let the pipeline settle.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.mismatches += sb.pending();

        $display("Covered %0d requests over %0d register settings; %0d results checked.",
                 sb.requests_seen, settings_used + 1, sb.results_seen);
        $display("Saw %0d padding elements, %0d stream ends, %0d mismatches.",
                 sb.pads_seen, sb.ends_seen, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/ipag_pkg.sv
rtl/ipag_ctrl.sv
rtl/ipag_dp.sv
rtl/im2col_patch_address_generator.sv
tb/im2col_patch_address_generator_tb.sv
